// ===== rtl/core/mdiom_pkg.sv =====
// Shared types and constants for the MDIO management master.
`timescale 1ns / 1ps

package mdiom_pkg;

  // Request codes on cmd; code 3 acts as a plain tick
  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_WRITE = 2'd2;

  // Configuration register indexes
  localparam logic CFG_PHY_ADDR = 1'b0;
  localparam logic CFG_HALF_PER = 1'b1;

  // Clause 22 opcodes
  localparam logic [1:0] OP_READ  = 2'b10;
  localparam logic [1:0] OP_WRITE = 2'b01;
  localparam logic [1:0] FRAME_ST = 2'b01;
  localparam logic [1:0] WR_TA    = 2'b10;

  localparam int DATA_BITS = 16;

  // Bit counts after the preamble
  localparam logic [5:0] HDR_BITS_RD  = 6'd14;  // start, op, phy, reg
  localparam logic [5:0] HDR_BITS_WR  = 6'd32;  // header, turnaround, data
  localparam logic [5:0] RECV_BITS    = 6'd18;  // turnaround plus data
  localparam logic [5:0] SAMPLE_LIMIT = 6'd16;

  typedef enum logic [3:0] {
    PH_IDLE  = 4'b0001,
    PH_PRE   = 4'b0010,
    PH_DRIVE = 4'b0100,
    PH_RECV  = 4'b1000
  } phase_t;

  typedef struct packed {
    logic        mdc;
    logic        mdio_out;
    logic        mdio_oe;
    logic        busy;
    logic [15:0] read_data;
    logic        read_done;
  } rslt_t;

endpackage

// ===== rtl/core/mdio_management_master_unit.sv =====
// Top level of the clause 22 MDIO management master: handshakes, config, result register.
`timescale 1ns / 1ps

//  channel | direction | handshake           | payload
//  in      | in        | in_valid/in_ready   | cmd, reg_addr, write_data, mdio_in
//  out     | out       | out_valid/out_ready | mdc, mdio_out, mdio_oe, busy_res,
//          |           |                     | read_data, read_done
//  cfg     | in        | cfg_valid/cfg_ready | cfg_index, cfg_data
//
//  Each tick taken yields one result in the next cycle; one per cycle unless stalled.
//  The frame step logic sits between the tick inputs and the result register.
//  Reset (rst, synchronous): idle, engine clock level low, phy_address 0, half period 4 ticks.
//  A stalled result holds in_ready low only while out_ready is low; cfg is always ready.

module mdio_management_master_unit #(
  parameter int PREAMBLE_BITS = 32,
  parameter int DIVIDER_WIDTH = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  cmd,
  input  logic [4:0]  reg_addr,
  input  logic [15:0] write_data,
  input  logic        mdio_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        mdc,
  output logic        mdio_out,
  output logic        mdio_oe,
  output logic        busy_res,
  output logic [15:0] read_data,
  output logic        read_done
);

  logic [4:0]       phy_address;
  logic [7:0]       half_period_ticks;
  logic             in_xfer;
  mdiom_pkg::rslt_t rslt;
  mdiom_pkg::rslt_t rslt_reg;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid || out_ready;
  assign in_xfer   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      phy_address       <= 5'd0;
      half_period_ticks <= 8'd4;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        mdiom_pkg::CFG_PHY_ADDR: phy_address       <= cfg_data[4:0];
        mdiom_pkg::CFG_HALF_PER: half_period_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  mdiom_engine #(
    .PREAMBLE_BITS(PREAMBLE_BITS),
    .DIVIDER_WIDTH(DIVIDER_WIDTH)
  ) u_engine (
    .clk              (clk),
    .rst              (rst),
    .step             (in_xfer),
    .phy_address      (phy_address),
    .half_period_ticks(half_period_ticks),
    .cmd              (cmd),
    .reg_addr         (reg_addr),
    .write_data       (write_data),
    .mdio_in          (mdio_in),
    .rslt             (rslt)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_xfer) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      rslt_reg <= rslt;
    end
  end

  assign mdc       = rslt_reg.mdc;
  assign mdio_out  = rslt_reg.mdio_out;
  assign mdio_oe   = rslt_reg.mdio_oe;
  assign busy_res  = rslt_reg.busy;
  assign read_data = rslt_reg.read_data;
  assign read_done = rslt_reg.read_done;

  a_out_needs_oe: assert property (@(posedge clk) disable iff (rst)
    out_valid && mdio_out |-> mdio_oe)
    else $error("mdio_out high while line released");

  a_done_ends_frame: assert property (@(posedge clk) disable iff (rst)
    out_valid && read_done |-> !busy_res && !mdio_oe)
    else $error("read_done while frame still busy");

  a_idle_clock_low: assert property (@(posedge clk) disable iff (rst)
    out_valid && !busy_res |-> !mdc && !mdio_oe)
    else $error("MDC or MDIO driven while idle");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(rslt_reg))
    else $error("result changed while stalled");

endmodule

// ===== rtl/core/mdiom_engine.sv =====
// Frame sequencer: divider, bit counter, shift registers, one step per transfer.
`timescale 1ns / 1ps

module mdiom_engine #(
  parameter int PREAMBLE_BITS = 32,
  parameter int DIVIDER_WIDTH = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  logic [4:0]           phy_address,
  input  logic [7:0]           half_period_ticks,
  input  logic [1:0]           cmd,
  input  logic [4:0]           reg_addr,
  input  logic [15:0]          write_data,
  input  logic                 mdio_in,
  output mdiom_pkg::rslt_t     rslt
);

  localparam logic [5:0]  PRE_LOAD = 6'(PREAMBLE_BITS % 64);
  // a 16-bit divider folds back to a limit of one tick
  localparam logic [16:0] HALF_LIM = 17'(1) << (DIVIDER_WIDTH % 16);

  mdiom_pkg::phase_t        phase, phase_next;
  logic [5:0]               bit_count, bit_count_next;
  logic [DIVIDER_WIDTH-1:0] tick_count, tick_count_next;
  logic                     clock_level, clock_level_next;
  logic [31:0]              out_shift, out_shift_next;
  logic [15:0]              in_shift, in_shift_next;
  logic                     is_read, is_read_next;
  logic [15:0]              last_read, last_read_next;
  logic                     done;

  logic [16:0] half_raw;
  logic [16:0] half_eff;
  logic [16:0] tick_inc;
  logic        half_end;
  logic        start_rd;
  logic [5:0]  bc_dec;

  always_comb begin
    half_raw = (half_period_ticks == 8'd0) ? 17'd1 : {9'd0, half_period_ticks};
    half_eff = (half_raw > HALF_LIM) ? HALF_LIM : half_raw;
    tick_inc = 17'(tick_count) + 17'd1;
    half_end = (tick_inc >= half_eff);
    start_rd = (cmd == mdiom_pkg::CMD_READ);
    bc_dec   = bit_count - 6'd1;
  end

  always_comb begin
    phase_next       = phase;
    bit_count_next   = bit_count;
    tick_count_next  = tick_count;
    clock_level_next = clock_level;
    out_shift_next   = out_shift;
    in_shift_next    = in_shift;
    is_read_next     = is_read;
    last_read_next   = last_read;
    done             = 1'b0;

    if (phase == mdiom_pkg::PH_IDLE) begin
      if (cmd == mdiom_pkg::CMD_READ || cmd == mdiom_pkg::CMD_WRITE) begin
        is_read_next     = start_rd;
        out_shift_next   = {mdiom_pkg::FRAME_ST,
                            start_rd ? mdiom_pkg::OP_READ : mdiom_pkg::OP_WRITE,
                            phy_address, reg_addr,
                            start_rd ? 2'b00 : mdiom_pkg::WR_TA,
                            start_rd ? 16'd0 : write_data};
        in_shift_next    = '0;
        tick_count_next  = '0;
        clock_level_next = 1'b0;
        if (PRE_LOAD != 6'd0) begin
          phase_next     = mdiom_pkg::PH_PRE;
          bit_count_next = PRE_LOAD;
        end else begin
          phase_next     = mdiom_pkg::PH_DRIVE;
          bit_count_next = start_rd ? mdiom_pkg::HDR_BITS_RD : mdiom_pkg::HDR_BITS_WR;
        end
      end
    end else if (half_end) begin
      tick_count_next = '0;
      if (!clock_level) begin
        // sample just before MDC rises, once past the read turnaround
        if (phase == mdiom_pkg::PH_RECV && bit_count <= mdiom_pkg::SAMPLE_LIMIT) begin
          in_shift_next = {in_shift[14:0], mdio_in};
        end
        clock_level_next = 1'b1;
      end else begin
        clock_level_next = 1'b0;
        bit_count_next   = bc_dec;
        if (bc_dec != 6'd0) begin
          if (phase == mdiom_pkg::PH_DRIVE) begin
            out_shift_next = {out_shift[30:0], 1'b0};
          end
        end else if (phase == mdiom_pkg::PH_PRE) begin
          phase_next     = mdiom_pkg::PH_DRIVE;
          bit_count_next = is_read ? mdiom_pkg::HDR_BITS_RD : mdiom_pkg::HDR_BITS_WR;
        end else if (phase == mdiom_pkg::PH_DRIVE && is_read) begin
          phase_next     = mdiom_pkg::PH_RECV;
          bit_count_next = mdiom_pkg::RECV_BITS;
        end else begin
          phase_next     = mdiom_pkg::PH_IDLE;
          out_shift_next = '0;
          if (is_read) begin
            last_read_next = in_shift;
            done           = 1'b1;
          end
        end
      end
    end else begin
      tick_count_next = tick_inc[DIVIDER_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= mdiom_pkg::PH_IDLE;
      bit_count   <= '0;
      tick_count  <= '0;
      clock_level <= 1'b0;
      is_read     <= 1'b0;
      last_read   <= '0;
    end else if (step) begin
      phase       <= phase_next;
      bit_count   <= bit_count_next;
      tick_count  <= tick_count_next;
      clock_level <= clock_level_next;
      is_read     <= is_read_next;
      last_read   <= last_read_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_shift <= out_shift_next;
      in_shift  <= in_shift_next;
    end
  end

  // Result reflects the state after this tick
  always_comb begin
    rslt.mdc       = clock_level_next;
    rslt.mdio_oe   = (phase_next == mdiom_pkg::PH_PRE) || (phase_next == mdiom_pkg::PH_DRIVE);
    rslt.mdio_out  = (phase_next == mdiom_pkg::PH_PRE) ||
                     ((phase_next == mdiom_pkg::PH_DRIVE) && out_shift_next[31]);
    rslt.busy      = (phase_next != mdiom_pkg::PH_IDLE);
    rslt.read_data = last_read_next;
    rslt.read_done = done;
  end

endmodule

// ===== tb/sv/mdio_management_master_checker.sv =====
// Scoreboard for the MDIO management master: predicts the result fields of every accepted tick and compares.
`timescale 1ns / 1ps

module mdio_management_master_checker #(
  parameter int PREAMBLE_BITS = 32,
  parameter int DIVIDER_WIDTH = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  cmd,
  input  logic [4:0]  reg_addr,
  input  logic [15:0] write_data,
  input  logic        mdio_in,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        mdc,
  input  logic        mdio_out,
  input  logic        mdio_oe,
  input  logic        busy_res,
  input  logic [15:0] read_data,
  input  logic        read_done,
  output int          mismatch_count,
  output int          results_due
);

  // a 16-bit divider folds back to a limit of one tick
  localparam logic [16:0] DIV_LIMIT = 17'd1 << (DIVIDER_WIDTH % 16);
  localparam logic [15:0] TICK_MASK = 16'(DIV_LIMIT - 17'd1);
  localparam logic [5:0]  PRE_COUNT = 6'(PREAMBLE_BITS % 64);

  // configuration copy
  logic [4:0]  phy_cfg;
  logic [7:0]  half_cfg;

  // frame state
  mdiom_pkg::phase_t cur_phase;
  logic [5:0]  bit_cnt;
  logic [15:0] tick_cnt;
  logic        clk_lvl;
  logic [31:0] out_sr;
  logic [15:0] in_sr;
  logic        rd_frame;
  logic [15:0] last_rd;

  mdiom_pkg::rslt_t expected_pins[$];

  function automatic logic [16:0] half_ticks();
    logic [16:0] h;
    h = {9'd0, half_cfg};
    if (h == 17'd0) h = 17'd1;
    if (h > DIV_LIMIT) h = DIV_LIMIT;
    return h;
  endfunction

  // falling MDC edge: next bit, phase change, or end of frame; 1 when a read completes
  function automatic logic end_of_bit();
    bit_cnt = bit_cnt - 6'd1;
    if (bit_cnt != 6'd0) begin
      if (cur_phase == mdiom_pkg::PH_DRIVE) out_sr = out_sr << 1;
      return 1'b0;
    end
    if (cur_phase == mdiom_pkg::PH_PRE) begin
      cur_phase = mdiom_pkg::PH_DRIVE;
      bit_cnt = rd_frame ? mdiom_pkg::HDR_BITS_RD : mdiom_pkg::HDR_BITS_WR;
      return 1'b0;
    end
    if (cur_phase == mdiom_pkg::PH_DRIVE && rd_frame) begin
      cur_phase = mdiom_pkg::PH_RECV;
      bit_cnt = mdiom_pkg::RECV_BITS;
      return 1'b0;
    end
    cur_phase = mdiom_pkg::PH_IDLE;
    out_sr = 32'd0;
    if (rd_frame) begin
      last_rd = in_sr;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic mdiom_pkg::rslt_t predict_tick(logic [1:0] c, logic [4:0] ra,
                                                    logic [15:0] wd, logic mi);
    mdiom_pkg::rslt_t r;
    logic  done;
    done = 1'b0;
    if (cur_phase == mdiom_pkg::PH_IDLE) begin
      if (c == mdiom_pkg::CMD_READ || c == mdiom_pkg::CMD_WRITE) begin
        rd_frame = (c == mdiom_pkg::CMD_READ);
        // read turnaround and data stay zero: the line is released then
        out_sr = {mdiom_pkg::FRAME_ST, rd_frame ? mdiom_pkg::OP_READ : mdiom_pkg::OP_WRITE,
                  phy_cfg, ra, rd_frame ? 2'b00 : mdiom_pkg::WR_TA,
                  rd_frame ? 16'h0000 : wd};
        in_sr = 16'd0;
        tick_cnt = 16'd0;
        clk_lvl = 1'b0;
        bit_cnt = PRE_COUNT;
        if (bit_cnt != 6'd0) begin
          cur_phase = mdiom_pkg::PH_PRE;
        end else begin
          cur_phase = mdiom_pkg::PH_DRIVE;
          bit_cnt = rd_frame ? mdiom_pkg::HDR_BITS_RD : mdiom_pkg::HDR_BITS_WR;
        end
      end
    end else if ({1'b0, tick_cnt} + 17'd1 >= half_ticks()) begin
      tick_cnt = 16'd0;
      if (!clk_lvl) begin
        // sample on the rising edge, skipping the two turnaround bits
        if (cur_phase == mdiom_pkg::PH_RECV && bit_cnt <= mdiom_pkg::SAMPLE_LIMIT)
          in_sr = {in_sr[14:0], mi};
        clk_lvl = 1'b1;
      end else begin
        clk_lvl = 1'b0;
        done = end_of_bit();
      end
    end else begin
      tick_cnt = (tick_cnt + 16'd1) & TICK_MASK;
    end
    r.mdc = clk_lvl;
    r.mdio_oe = (cur_phase == mdiom_pkg::PH_PRE || cur_phase == mdiom_pkg::PH_DRIVE);
    r.mdio_out = (cur_phase == mdiom_pkg::PH_PRE) ? 1'b1 :
                 (cur_phase == mdiom_pkg::PH_DRIVE) ? out_sr[31] : 1'b0;
    r.busy = (cur_phase != mdiom_pkg::PH_IDLE);
    r.read_data = last_rd;
    r.read_done = done;
    return r;
  endfunction

  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $display("%0t ns: %s expected %h, got %h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin : monitor
    mdiom_pkg::rslt_t want;
    if (rst) begin
      phy_cfg = 5'd0;
      half_cfg = 8'd4;
      cur_phase = mdiom_pkg::PH_IDLE;
      bit_cnt = 6'd0;
      tick_cnt = 16'd0;
      clk_lvl = 1'b0;
      out_sr = 32'd0;
      in_sr = 16'd0;
      rd_frame = 1'b0;
      last_rd = 16'd0;
      expected_pins.delete();
      mismatch_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == mdiom_pkg::CFG_PHY_ADDR) phy_cfg = cfg_data[4:0];
        else half_cfg = cfg_data;
      end
      // a result is registered after its tick, so compare before predicting
      if (out_valid && out_ready) begin
        if (expected_pins.size() == 0) begin
          $display("%0t ns: result transfer with no tick outstanding", $time);
          mismatch_count++;
        end else begin
          want = expected_pins.pop_front();
          check_field("mdc", 16'(want.mdc), 16'(mdc));
          check_field("mdio_out", 16'(want.mdio_out), 16'(mdio_out));
          check_field("mdio_oe", 16'(want.mdio_oe), 16'(mdio_oe));
          check_field("busy_res", 16'(want.busy), 16'(busy_res));
          check_field("read_data", want.read_data, read_data);
          check_field("read_done", 16'(want.read_done), 16'(read_done));
        end
      end
      if (in_valid && in_ready)
        expected_pins.push_back(predict_tick(cmd, reg_addr, write_data, mdio_in));
    end
    results_due = expected_pins.size();
  end

endmodule

// ===== tb/sv/tb_mdio_management_master_unit.sv =====
// Testbench top for the MDIO management master: frame stimulus, handshake pacing, verdict.
`timescale 1ns / 1ps

module tb_mdio_management_master_unit;

  localparam int PRE_BITS    = 32;
  localparam int DIV_W       = 8;
  localparam int CYCLE_LIMIT = 600000;

  // code 3 behaves like a plain tick
  localparam logic [1:0] CMD_SPARE = 2'd3;

  localparam int MDIO_RANDOM = 0;
  localparam int MDIO_HIGH   = 1;
  localparam int MDIO_LOW    = 2;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_index = mdiom_pkg::CFG_PHY_ADDR;
  logic [7:0]  cfg_data = 8'd0;
  logic        in_valid = 1'b0;
  logic [1:0]  cmd = mdiom_pkg::CMD_TICK;
  logic [4:0]  reg_addr = 5'd0;
  logic [15:0] write_data = 16'd0;
  logic        mdio_in = 1'b0;
  logic        out_ready = 1'b1;
  logic        cfg_ready;
  logic        in_ready;
  logic        out_valid;
  logic        mdc;
  logic        mdio_out;
  logic        mdio_oe;
  logic        busy_res;
  logic [15:0] read_data;
  logic        read_done;

  int mismatch_count;
  int results_due;
  int cycle_count = 0;
  int ticks_sent = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int mdio_mode = MDIO_RANDOM;
  int half_now = 4;

  mdio_management_master_unit #(
    .PREAMBLE_BITS(PRE_BITS),
    .DIVIDER_WIDTH(DIV_W)
  ) dut (.*);

  mdio_management_master_checker #(
    .PREAMBLE_BITS(PRE_BITS),
    .DIVIDER_WIDTH(DIV_W)
  ) checker_i (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  always @(negedge clk) begin
    out_ready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("mdio_management_master_unit regression: fail");
      $finish;
    end
  end

  task automatic wait_drained();
    do begin
      @(negedge clk);
      in_valid <= 1'b0;
    end while (results_due != 0);
  endtask

  task automatic set_reg(logic idx, logic [7:0] val);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    if (idx == mdiom_pkg::CFG_HALF_PER) half_now = val;
  endtask

  task automatic send_tick(logic [1:0] c, logic [4:0] ra, logic [15:0] wd);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    cmd <= c;
    reg_addr <= ra;
    write_data <= wd;
    mdio_in <= (mdio_mode == MDIO_HIGH) ? 1'b1 :
               (mdio_mode == MDIO_LOW) ? 1'b0 : 1'($urandom_range(1));
    do @(posedge clk); while (!in_ready);
    ticks_sent++;
  endtask

  task automatic send_plain(int count);
    repeat (count)
      send_tick(mdiom_pkg::CMD_TICK, 5'($urandom_range(31)), 16'($urandom_range(16'hFFFF)));
  endtask

  // one request, then ticks through the frame; now and then the next request
  // lands on or just before the closing tick and is dropped
  task automatic run_frame(logic [1:0] c, logic [4:0] ra, logic [15:0] wd);
    int len;
    int extra;
    logic [1:0] fc;
    len = (PRE_BITS + 32) * 2 * ((half_now == 0) ? 1 : half_now);
    extra = ($urandom_range(9) == 0) ? 0 : $urandom_range(4, 1);
    send_tick(c, ra, wd);
    for (int i = 0; i < len - 2 + extra; i++) begin
      fc = mdiom_pkg::CMD_TICK;
      if (i < len - 2 && $urandom_range(24) == 0)
        fc = $urandom_range(1) ? mdiom_pkg::CMD_READ : mdiom_pkg::CMD_WRITE;  // dropped
      else if ($urandom_range(19) == 0)
        fc = CMD_SPARE;
      send_tick(fc, 5'($urandom_range(31)), 16'($urandom_range(16'hFFFF)));
    end
  endtask

  initial begin : stimulus
    int phase_start;
    logic [7:0] half_pick;

    repeat (12) @(negedge clk);
    rst <= 1'b0;

    send_tick(mdiom_pkg::CMD_TICK, 5'd31, 16'hFFFF);
    send_tick(CMD_SPARE, 5'd0, 16'h0000);
    set_reg(mdiom_pkg::CFG_PHY_ADDR, 8'd0);
    mdio_mode = MDIO_HIGH;
    // reset half period for the first eight bits, then one tick for the rest
    send_tick(mdiom_pkg::CMD_READ, 5'd0, 16'h0000);
    send_plain(63);
    set_reg(mdiom_pkg::CFG_HALF_PER, 8'd1);
    send_plain(118);
    set_reg(mdiom_pkg::CFG_PHY_ADDR, 8'd31);
    run_frame(mdiom_pkg::CMD_WRITE, 5'd31, 16'hFFFF);
    mdio_mode = MDIO_LOW;
    // zero half period counts as one tick
    set_reg(mdiom_pkg::CFG_HALF_PER, 8'd0);
    set_reg(mdiom_pkg::CFG_PHY_ADDR, 8'h15);
    run_frame(mdiom_pkg::CMD_READ, 5'h0A, 16'h0000);
    mdio_mode = MDIO_RANDOM;

    // slowest divide through the first low half period, then speed up mid-frame
    set_reg(mdiom_pkg::CFG_HALF_PER, 8'd255);
    send_tick(mdiom_pkg::CMD_WRITE, 5'h15, 16'hA5C3);
    send_plain(256);
    set_reg(mdiom_pkg::CFG_HALF_PER, 8'd1);
    send_plain(130);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 78;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 78;
        end
        default: begin
          send_idle_pct = 29;
          recv_stall_pct = 29;
        end
      endcase
      half_pick = (ph == 0) ? 8'd2 : 8'd1;
      set_reg(mdiom_pkg::CFG_PHY_ADDR, 8'($urandom_range(31)));
      set_reg(mdiom_pkg::CFG_HALF_PER, half_pick);
      phase_start = ticks_sent;
      while (ticks_sent - phase_start < 100) begin
        if ($urandom_range(7) == 0) mdio_mode = $urandom_range(1) ? MDIO_HIGH : MDIO_LOW;
        else mdio_mode = MDIO_RANDOM;
        run_frame($urandom_range(1) ? mdiom_pkg::CMD_READ : mdiom_pkg::CMD_WRITE,
                  5'($urandom_range(31)), 16'($urandom_range(16'hFFFF)));
        // hold off until the result side has caught up
        if ($urandom_range(5) == 0) wait_drained();
      end
    end

    wait_drained();
    repeat (8) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("mdio_management_master_unit regression: pass");
    end else begin
      $display("mdio_management_master_unit regression: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/mdiom_pkg.sv
rtl/core/mdiom_engine.sv
rtl/core/mdio_management_master_unit.sv
tb/sv/mdio_management_master_checker.sv
tb/sv/tb_mdio_management_master_unit.sv
